// File: rtl/tti_pkg.sv
package tti_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ModeW  = 8;

  localparam logic [0:0] CfgPointCount = 1'b0;
  localparam logic [0:0] CfgHoldMode   = 1'b1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] StInside     = 2'd0;
  localparam logic [1:0] StClampFirst = 2'd1;
  localparam logic [1:0] StClampLast  = 2'd2;
  localparam logic [1:0] StEmpty      = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] tim;
    logic [DataW-1:0] spd;
    logic [DataW-1:0] pos;
    logic [DataW-1:0] frc;
    logic [ModeW-1:0] mode;
  } point_t;

  localparam int unsigned PointW = 4 * DataW + ModeW;

  typedef struct packed {
    logic             op;
    logic [IdxW-1:0]  entry_index;
    logic [DataW-1:0] time_value;
    logic [DataW-1:0] speed_value;
    logic [DataW-1:0] position_value;
    logic [DataW-1:0] force_value;
    logic [ModeW-1:0] mode_value;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] out_time;
    logic [DataW-1:0] out_speed;
    logic [DataW-1:0] out_position;
    logic [DataW-1:0] out_force;
    logic [ModeW-1:0] out_mode;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic [0:0]       index;
    logic [DataW-1:0] data;
  } cfg_t;

endpackage

// File: rtl/tti_if.sv
interface tti_req_if;
  logic           valid;
  logic           ready;
  tti_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tti_rsp_if;
  logic           valid;
  logic           ready;
  tti_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tti_cfg_if;
  logic           valid;
  logic           ready;
  tti_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/trajectory_time_interpolator_core.sv
// Trajectory time interpolator.
// A request on req carries op. A write request stores one point (time, speed,
// position, force, mode) at entry_index and gives no response. A query request
// gives one response on rsp: the point clamped to the first or last entry, the
// earlier point of the interval in hold mode, speed and position interpolated
// linearly between the two points around the query time, or an empty status.
// The cfg channel writes point_count (index 0) and hold_mode (index 1).
// A write leaves the block idle, so the next request can follow at once.
// A query runs a binary search in which each step issues two table memory
// reads and then a decision. Interpolation runs in the shared unit, which
// runs a two-step multiply and a 66-step restoring division once for speed
// and once for position. Clamped and hold queries skip the interpolation.
// The table lives in one synchronous memory, one point per word; its contents
// are undefined after reset, and both registers reset to zero. Only one
// request is in work at a time. A finished response sits in an output register
// until taken; a stalled receiver holds the block, which then takes no new
// request until the response register is free.
module trajectory_time_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  tti_req_if.sink   req,
  tti_cfg_if.sink   cfg,
  tti_rsp_if.source rsp
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = AW + 1;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SRdFst  = 4'd1;
  localparam logic [3:0] SRdLst  = 4'd2;
  localparam logic [3:0] SChkLst = 4'd3;
  localparam logic [3:0] SMid    = 4'd4;
  localparam logic [3:0] SMidNx  = 4'd5;
  localparam logic [3:0] SJudge  = 4'd6;
  localparam logic [3:0] SRdP0   = 4'd7;
  localparam logic [3:0] SRdP1   = 4'd8;
  localparam logic [3:0] SLerpS  = 4'd9;
  localparam logic [3:0] SLerpP  = 4'd10;
  localparam logic [3:0] SOut    = 4'd11;
  localparam logic [3:0] SRdW    = 4'd12;

  logic [3:0]  st_q, st_d;
  logic [tti_pkg::CountW-1:0] cnt_q, cnt_d;
  logic        hold_q, hold_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] left_q, left_d, right_q, right_d;
  logic [AW-1:0] mid_q, mid_d, idx_q, idx_d;
  logic [31:0]  t_q, t_d;
  tti_pkg::point_t p0_q, p0_d, p1_q, p1_d;
  logic        tmid_le_q, tmid_le_d;
  logic [31:0] spd_res_q, spd_res_d;
  tti_pkg::rsp_t rsp_q, rsp_d;
  logic        rsp_v_q, rsp_v_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  tti_pkg::point_t wdata, rdata;
  logic          lerp_start, lerp_done;
  logic [31:0]   lerp_t1, lerp_v0, lerp_v1, lerp_res;
  logic          req_fire, in_range;
  logic [NW-1:0] nm1;

  tti_ram #(.Width(tti_pkg::PointW), .Depth(TABLE_DEPTH)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  tti_lerp u_lerp (
    .clk_i, .rst_ni, .start_i(lerp_start), .t_i(t_q), .t0_i(p0_q.tim),
    .t1_i(lerp_t1), .v0_i(lerp_v0), .v1_i(lerp_v1), .done_o(lerp_done),
    .res_o(lerp_res)
  );

  assign req.ready = (st_q == SIdle) && !rsp_v_q;
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;
  assign nm1       = n_q - NW'(1);
  assign in_range  = NW'(req.data.entry_index) < NW'(TABLE_DEPTH);

  assign we    = req_fire && (req.data.op == tti_pkg::OpWrite) && in_range;
  assign waddr = AW'(req.data.entry_index);
  assign wdata = '{tim: req.data.time_value, spd: req.data.speed_value,
                   pos: req.data.position_value, frc: req.data.force_value,
                   mode: req.data.mode_value};
  assign lerp_start = (st_q == SRdP1 && !hold_q) || (st_q == SLerpS && lerp_done);
  assign lerp_t1 = (st_q == SRdP1) ? rdata.tim : p1_q.tim;
  assign lerp_v0 = (st_q == SRdP1) ? p0_q.spd : p0_q.pos;
  assign lerp_v1 = (st_q == SRdP1) ? rdata.spd : p1_q.pos;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; hold_d = hold_q; n_d = n_q; left_d = left_q;
    right_d = right_q; mid_d = mid_q; idx_d = idx_q; t_d = t_q; p0_d = p0_q;
    p1_d = p1_q; tmid_le_d = tmid_le_q; spd_res_d = spd_res_q; rsp_d = rsp_q;
    rsp_v_d = rsp_v_q; raddr = '0;
    if (rsp_v_q && rsp.ready) begin
      rsp_v_d = 1'b0;
    end
    if (cfg.valid) begin
      unique case (cfg.data.index)
        tti_pkg::CfgPointCount: cnt_d = cfg.data.data[tti_pkg::CountW-1:0];
        tti_pkg::CfgHoldMode:   hold_d = cfg.data.data[0];
        default: ;
      endcase
    end
    unique case (st_q)
      SIdle: begin
        if (req_fire && req.data.op == tti_pkg::OpQuery) begin
          t_d = req.data.time_value;
          if (cnt_q == '0) begin
            rsp_d = '0;
            rsp_d.status = tti_pkg::StEmpty;
            rsp_v_d = 1'b1;
          end else begin
            n_d = (32'(cnt_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(cnt_q);
            st_d = SRdFst;
          end
        end
      end
      SRdFst: begin
        raddr = '0;
        st_d  = SRdLst;
      end
      SRdLst: begin
        raddr = AW'(nm1);
        if (t_q <= rdata.tim) begin
          rsp_d = '{out_time: rdata.tim, out_speed: rdata.spd,
                    out_position: rdata.pos, out_force: rdata.frc,
                    out_mode: rdata.mode, status: tti_pkg::StClampFirst};
          st_d = SOut;
        end else begin
          st_d = SChkLst;
        end
      end
      SChkLst: begin
        if (t_q >= rdata.tim) begin
          rsp_d = '{out_time: rdata.tim, out_speed: rdata.spd,
                    out_position: rdata.pos, out_force: rdata.frc,
                    out_mode: rdata.mode, status: tti_pkg::StClampLast};
          st_d = SOut;
        end else begin
          left_d  = '0;
          right_d = nm1;
          st_d    = SMid;
        end
      end
      SMid: begin
        if (left_q < right_q) begin
          mid_d = AW'(left_q + ((right_q - left_q) >> 1));
          raddr = AW'(left_q + ((right_q - left_q) >> 1));
          st_d  = SMidNx;
        end else begin
          idx_d = AW'(left_q);
          st_d  = SRdW;
        end
      end
      SMidNx: begin
        raddr = AW'(NW'(mid_q) + NW'(1));
        tmid_le_d = (rdata.tim <= t_q);
        st_d = SJudge;
      end
      SJudge: begin
        if (tmid_le_q && (NW'(mid_q) == nm1 || rdata.tim > t_q)) begin
          idx_d = mid_q;
          st_d  = SRdW;
        end else if (!tmid_le_q) begin
          right_d = NW'(mid_q);
          st_d    = SMid;
        end else begin
          left_d = NW'(mid_q) + NW'(1);
          st_d   = SMid;
        end
      end
      SRdW: begin
        raddr = idx_q;
        if (NW'(idx_q) >= nm1) begin
          raddr = AW'(nm1);
        end
        st_d = SRdP0;
      end
      SRdP0: begin
        raddr = AW'(NW'(idx_q) + NW'(1));
        p0_d  = rdata;
        if (NW'(idx_q) >= nm1) begin
          rsp_d = '{out_time: rdata.tim, out_speed: rdata.spd,
                    out_position: rdata.pos, out_force: rdata.frc,
                    out_mode: rdata.mode, status: tti_pkg::StClampLast};
          st_d = SOut;
        end else if (hold_q) begin
          rsp_d = '{out_time: rdata.tim, out_speed: rdata.spd,
                    out_position: rdata.pos, out_force: rdata.frc,
                    out_mode: rdata.mode, status: tti_pkg::StInside};
          st_d = SOut;
        end else begin
          st_d = SRdP1;
        end
      end
      SRdP1: begin
        p1_d = rdata;
        st_d = SLerpS;
      end
      SLerpS: begin
        if (lerp_done) begin
          spd_res_d = lerp_res;
          st_d = SLerpP;
        end
      end
      SLerpP: begin
        if (lerp_done) begin
          rsp_d = '{out_time: t_q, out_speed: spd_res_q, out_position: lerp_res,
                    out_force: p0_q.frc, out_mode: p0_q.mode,
                    status: tti_pkg::StInside};
          st_d = SOut;
        end
      end
      SOut: begin
        rsp_v_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      cnt_q   <= '0;
      hold_q  <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
      rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; left_q <= left_d; right_q <= right_d; mid_q <= mid_d;
    idx_q <= idx_d; t_q <= t_d; p0_q <= p0_d; p1_q <= p1_d;
    tmid_le_q <= tmid_le_d; spd_res_q <= spd_res_d; rsp_q <= rsp_d;
  end

  NoAcceptBusy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> st_q == SIdle && !rsp_v_q) else $error("request taken while busy");
  RspHeld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && !rsp.ready |=> rsp_v_q && $stable(rsp_q)) else $error("response lost");
  SearchBound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SMid |-> left_q <= right_q) else $error("search bounds crossed");
  OutFromWork: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SOut |-> !rsp_v_q) else $error("response overwrite");
endmodule

// File: rtl/tti_ram.sv
module tti_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/tti_lerp.sv
module tti_lerp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] t_i,
  input  logic [31:0] t0_i,
  input  logic [31:0] t1_i,
  input  logic [31:0] v0_i,
  input  logic [31:0] v1_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMulA = 3'd1;
  localparam logic [2:0] SMulB = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [32:0] adv_q, adv_d;
  logic [32:0] adt_q, adt_d;
  logic [32:0] asp_q, asp_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic [31:0] v0_q, v0_d;
  logic [65:0] prod_q, prod_d;
  logic [65:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [31:0] res_q, res_d;

  logic signed [33:0] dv, dt, sp;
  logic [33:0] trial;
  logic [34:0] qc;
  logic signed [35:0] r;

  assign dv = 34'(signed'(v1_i)) - 34'(signed'(v0_i));
  assign dt = 34'(signed'({1'b0, t_i})) - 34'(signed'({1'b0, t0_i}));
  assign sp = 34'(signed'({1'b0, t1_i})) - 34'(signed'({1'b0, t0_i}));
  assign trial = {rem_q[32:0], quo_q[65]};

  always_comb begin
    st_d = st_q; adv_d = adv_q; adt_d = adt_q; asp_d = asp_q; neg_d = neg_q;
    zero_d = zero_q; v0_d = v0_q; prod_d = prod_q; quo_d = quo_q; rem_d = rem_q;
    cnt_d = cnt_q; done_d = 1'b0; res_d = res_q;
    qc = '0; r = '0;
    unique case (st_q)
      SIdle: begin
        if (start_i) begin
          adv_d  = dv[33] ? 33'(-dv) : dv[32:0];
          adt_d  = dt[33] ? 33'(-dt) : dt[32:0];
          asp_d  = sp[33] ? 33'(-sp) : sp[32:0];
          neg_d  = dv[33] ^ dt[33] ^ sp[33];
          zero_d = (sp == '0);
          v0_d   = v0_i;
          st_d   = SMulA;
        end
      end
      SMulA: begin
        prod_d = 66'(adv_q[32:16] * adt_q);
        st_d   = SMulB;
      end
      SMulB: begin
        prod_d = (prod_q << 16) + 66'(adv_q[15:0] * adt_q);
        quo_d  = '0;
        rem_d  = '0;
        cnt_d  = 7'd66;
        st_d   = SDiv;
      end
      SDiv: begin
        if (cnt_q == 7'd66) begin
          quo_d = prod_q;
          cnt_d = 7'd65;
        end else begin
          if (trial >= 34'(asp_q)) begin
            rem_d = trial - 34'(asp_q);
            quo_d = {quo_q[64:0], 1'b1};
          end else begin
            rem_d = trial;
            quo_d = {quo_q[64:0], 1'b0};
          end
          if (cnt_q == '0) begin
            st_d = SFin;
          end else begin
            cnt_d = cnt_q - 7'd1;
          end
        end
      end
      SFin: begin
        qc = (quo_q > 66'(35'h4_0000_0000)) ? 35'h4_0000_0000 : quo_q[34:0];
        r = neg_q ? 36'(signed'(v0_q)) - 36'(qc) : 36'(signed'(v0_q)) + 36'(qc);
        if (zero_q) begin
          res_d = v0_q;
        end else if (r > 36'sh0_7FFF_FFFF) begin
          res_d = 32'h7FFF_FFFF;
        end else if (r < -36'sh0_8000_0000) begin
          res_d = 32'h8000_0000;
        end else begin
          res_d = r[31:0];
        end
        done_d = 1'b1;
        st_d   = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adv_q <= adv_d; adt_q <= adt_d; asp_q <= asp_d; neg_q <= neg_d;
    zero_q <= zero_d; v0_q <= v0_d; prod_q <= prod_d; quo_q <= quo_d;
    rem_q <= rem_d; cnt_q <= cnt_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  DoneFromFin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q) == SFin) else $error("lerp done without finish");
  StartWhenIdle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SMulA) |-> $past(st_q) == SIdle) else $error("lerp start order");
  FinAfterDiv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SFin) |-> $past(st_q) == SDiv) else $error("lerp finish order");
endmodule
